[rtl/ddgl_pkg.sv]
`timescale 1ns / 1ps

package ddgl_pkg;

  // Input and result field widths.
  localparam int DATA_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int NDIG_W     = 4;
  localparam int X_W        = 12;
  localparam int CANVAS_W   = 13;
  localparam int BIT_CNT_W  = $clog2(DATA_W);

  // Configuration register widths and reset values.
  localparam int PITCH_W         = 8;
  localparam int MIN_DIG_W       = 5;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 32;
  localparam int GLYPH_WIDTH_RST = 8;

  // Default cell limit.
  localparam int DEF_MAX_CELLS = 16;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_DIGIT_SPACE = 3'd0,
    REG_GLYPH_WIDTH = 3'd1,
    REG_MIN_DIGITS  = 3'd2,
    REG_ZERO_FILL   = 3'd3,
    REG_FORCE_SIGN  = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_SCALE,
    ST_EMIT
  } state_t;

endpackage

[rtl/decimal_digit_glyph_layout_unit.sv]
`timescale 1ns / 1ps

// Lays out a signed 32-bit value as fixed-pitch decimal digit cells and sends
// one beat per cell, rightmost cell first; m_tlast marks the leftmost cell sent.
// The magnitude is converted to BCD by a bit-serial shift-and-add-3 converter
// that takes one input bit per cycle; the digit count is then found, the
// layout is scaled and the cells are sent, one beat per cycle when the sink
// is ready. One value is processed at a time and a new value is taken once
// the last cell has left. Configuration registers sit on the APB port at byte
// addresses 0x00 (digit_space), 0x04 (glyph_width), 0x08 (min_digits), 0x0C
// (zero_fill) and 0x10 (force_sign) and should be written only while the
// block is idle.
module decimal_digit_glyph_layout_unit #(
  parameter int MAX_CELLS = ddgl_pkg::DEF_MAX_CELLS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream: s_tdata[31:0] = number
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ddgl_pkg::DATA_W-1:0]     s_tdata,
  // Output stream: [3:0] glyph, [15:4] x_pos, [16] draw,
  // [29:17] canvas_width, [31:30] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,
  output logic                            m_tlast,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ddgl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ddgl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ddgl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CELL_W = $clog2(MAX_CELLS + 2);
  localparam int CMP_W  = (CELL_W > ddgl_pkg::MIN_DIG_W) ? CELL_W : ddgl_pkg::MIN_DIG_W;
  localparam int PROD_W = CELL_W + ddgl_pkg::PITCH_W;
  localparam int ACC_W  = (PROD_W > ddgl_pkg::CANVAS_W) ? PROD_W : ddgl_pkg::CANVAS_W;

  // Configuration registers.
  logic [ddgl_pkg::PITCH_W-1:0]   digit_space;
  logic [ddgl_pkg::PITCH_W-1:0]   glyph_width;
  logic [ddgl_pkg::MIN_DIG_W-1:0] min_digits;
  logic                           zero_fill;
  logic                           force_sign;

  ddgl_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  // Datapath registers.
  ddgl_pkg::state_t               state;
  ddgl_pkg::state_t               state_next;
  logic [ddgl_pkg::DATA_W-1:0]    mag;
  logic [ddgl_pkg::BCD_W-1:0]     bcd;
  logic [ddgl_pkg::BCD_W-1:0]     bcd_adj;
  logic [ddgl_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic                           negative;
  logic                           sign_cell;
  logic [ddgl_pkg::NDIG_W-1:0]    ndig;
  logic [ddgl_pkg::NDIG_W-1:0]    ndig_next;
  logic [CELL_W-1:0]              cells;
  logic [CELL_W-1:0]              cells_next;
  logic [CELL_W-1:0]              cell_idx;
  logic [ddgl_pkg::PITCH_W-1:0]   pitch;
  logic [ddgl_pkg::CANVAS_W-1:0]  total;
  logic [ddgl_pkg::CANVAS_W-1:0]  xrun;
  logic [CELL_W-1:0]              ncell;
  logic [ACC_W-1:0]               prod_total;
  logic [ACC_W-1:0]               prod_x;

  logic in_beat;
  logic out_beat;
  logic is_digit;
  logic last_cell;
  logic [ddgl_pkg::DIGIT_W-1:0] glyph;

  // APB decode; the register index comes from the word address.
  assign pready    = 1'b1;
  assign reg_idx   = ddgl_pkg::reg_idx_t'(paddr[ddgl_pkg::APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_space <= '0;
      glyph_width <= ddgl_pkg::PITCH_W'(ddgl_pkg::GLYPH_WIDTH_RST);
      min_digits  <= '0;
      zero_fill   <= 1'b0;
      force_sign  <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        ddgl_pkg::REG_DIGIT_SPACE: digit_space <= pwdata[ddgl_pkg::PITCH_W-1:0];
        ddgl_pkg::REG_GLYPH_WIDTH: glyph_width <= pwdata[ddgl_pkg::PITCH_W-1:0];
        ddgl_pkg::REG_MIN_DIGITS:  min_digits  <= pwdata[ddgl_pkg::MIN_DIG_W-1:0];
        ddgl_pkg::REG_ZERO_FILL:   zero_fill   <= pwdata[0];
        ddgl_pkg::REG_FORCE_SIGN:  force_sign  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      ddgl_pkg::REG_DIGIT_SPACE: prdata = ddgl_pkg::APB_DATA_W'(digit_space);
      ddgl_pkg::REG_GLYPH_WIDTH: prdata = ddgl_pkg::APB_DATA_W'(glyph_width);
      ddgl_pkg::REG_MIN_DIGITS:  prdata = ddgl_pkg::APB_DATA_W'(min_digits);
      ddgl_pkg::REG_ZERO_FILL:   prdata = ddgl_pkg::APB_DATA_W'(zero_fill);
      ddgl_pkg::REG_FORCE_SIGN:  prdata = ddgl_pkg::APB_DATA_W'(force_sign);
      default:                   prdata = '0;
    endcase
  end

  // A zero digit pitch falls back to the glyph width.
  assign pitch = (digit_space != '0) ? digit_space : glyph_width;

  // One shift-and-add-3 step: every BCD digit of five or more gets three added.
  always_comb begin
    for (int d = 0; d < ddgl_pkg::NUM_DIGITS; d++) begin
      if (bcd[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W] >= ddgl_pkg::DIGIT_W'(5)) begin
        bcd_adj[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W] =
          bcd[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W] + ddgl_pkg::DIGIT_W'(3);
      end else begin
        bcd_adj[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W] =
          bcd[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W];
      end
    end
  end

  // Digit count is the position of the highest nonzero digit; zero has one digit.
  always_comb begin
    ndig_next = ddgl_pkg::NDIG_W'(1);
    for (int d = 1; d < ddgl_pkg::NUM_DIGITS; d++) begin
      if (bcd[d*ddgl_pkg::DIGIT_W +: ddgl_pkg::DIGIT_W] != '0) begin
        ndig_next = ddgl_pkg::NDIG_W'(d + 1);
      end
    end
  end

  // Cell count is the larger of digit count and minimum, capped at the limit.
  always_comb begin
    logic [CMP_W-1:0] want;
    want = (CMP_W'(ndig_next) > CMP_W'(min_digits)) ? CMP_W'(ndig_next)
                                                    : CMP_W'(min_digits);
    if (want > CMP_W'(MAX_CELLS)) begin
      want = CMP_W'(MAX_CELLS);
    end
    cells_next = CELL_W'(want);
  end

  // Canvas width and the x offset of the rightmost cell.
  assign ncell      = cells + CELL_W'(sign_cell);
  assign prod_total = ACC_W'(PROD_W'(ncell) * PROD_W'(pitch));
  assign prod_x     = ACC_W'(PROD_W'(ncell - CELL_W'(1)) * PROD_W'(pitch));

  // Handshakes.
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddgl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ddgl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ddgl_pkg::ST_CONV;
        end
      end
      ddgl_pkg::ST_CONV: begin
        if (bit_cnt == '1) begin
          state_next = ddgl_pkg::ST_COUNT;
        end
      end
      ddgl_pkg::ST_COUNT: begin
        state_next = ddgl_pkg::ST_SCALE;
      end
      ddgl_pkg::ST_SCALE: begin
        state_next = ddgl_pkg::ST_EMIT;
      end
      ddgl_pkg::ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready && last_cell) begin
          state_next = ddgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ddgl_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: load, convert bit by bit, size the layout, then walk the cells.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      negative <= s_tdata[ddgl_pkg::DATA_W-1];
      mag      <= s_tdata[ddgl_pkg::DATA_W-1] ? (~s_tdata + ddgl_pkg::DATA_W'(1)) : s_tdata;
      bcd      <= '0;
      bit_cnt  <= '0;
    end
    if (state == ddgl_pkg::ST_CONV) begin
      {bcd, mag} <= {bcd_adj[ddgl_pkg::BCD_W-2:0], mag, 1'b0};
      bit_cnt    <= bit_cnt + ddgl_pkg::BIT_CNT_W'(1);
    end
    if (state == ddgl_pkg::ST_COUNT) begin
      ndig      <= ndig_next;
      cells     <= cells_next;
      sign_cell <= negative || force_sign;
    end
    if (state == ddgl_pkg::ST_SCALE) begin
      total    <= prod_total[ddgl_pkg::CANVAS_W-1:0];
      xrun     <= prod_x[ddgl_pkg::CANVAS_W-1:0];
      cell_idx <= '0;
    end
    if (out_beat) begin
      bcd      <= {ddgl_pkg::DIGIT_W'(0), bcd[ddgl_pkg::BCD_W-1:ddgl_pkg::DIGIT_W]};
      xrun     <= xrun - ddgl_pkg::CANVAS_W'(pitch);
      cell_idx <= cell_idx + CELL_W'(1);
    end
  end

  // Current cell fields.
  assign is_digit  = CMP_W'(cell_idx) < CMP_W'(ndig);
  assign last_cell = (cell_idx + CELL_W'(1)) == cells;
  assign glyph     = is_digit ? bcd[ddgl_pkg::DIGIT_W-1:0] : '0;

  assign m_tdata = {2'b00, total, (is_digit || zero_fill), xrun[ddgl_pkg::X_W-1:0], glyph};
  assign m_tlast = last_cell;

`ifndef SYNTH
  // Only one value is in flight: no input is taken while cells are sent.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while cells are pending");

  // The cell walk never passes the cell count.
  a_cell_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ddgl_pkg::ST_EMIT) |-> (cell_idx < cells))
    else $error("cell index beyond cell count");

  // An undrawn cell is a padding cell and shows the zero glyph.
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[16]) |-> (m_tdata[3:0] == 4'd0))
    else $error("blank cell carries a nonzero glyph");

  // After a non-final cell is taken, the next cell of the same value follows.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !m_tlast) |=> (m_tvalid && $stable(total)))
    else $error("cell run broken before its last cell");
`endif

endmodule
